// ----- src/pfx_pkg.sv -----
package pfx_pkg;

	// Default operand stack depth
	localparam int unsigned STACK_DEPTH_DEF = 64;

	// Data word width of the stack and the arithmetic
	localparam int unsigned WORD_W = 32;

	// Expression characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_DIVZERO   = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RHS,
		S_LHS,
		S_EXEC,
		S_DIV,
		S_PUSH,
		S_FINISH,
		S_EMIT
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		word_t quotient;
	} div_rsp_t;

endpackage

// ----- src/pfx_if.sv -----
interface pfx_expr_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

interface pfx_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [pfx_pkg::WORD_W-1:0]  value;
	logic [1:0]                          status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// ----- src/pfx_div.sv -----
module pfx_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfx_pkg::div_req_t req,
	output pfx_pkg::div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(pfx_pkg::WORD_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        neg_q;
	pfx_pkg::word_t              rem_q;
	pfx_pkg::word_t              quo_q;
	pfx_pkg::word_t              dvs_q;
	logic                        a_neg;
	logic                        b_neg;
	pfx_pkg::word_t              a_mag;
	pfx_pkg::word_t              b_mag;
	logic [pfx_pkg::WORD_W:0]    rem_shift;
	logic [pfx_pkg::WORD_W:0]    diff;

	// Take magnitudes of the operands
	always_comb begin
		a_neg = req.dividend[pfx_pkg::WORD_W-1];
		b_neg = req.divisor[pfx_pkg::WORD_W-1];
		a_mag = a_neg ? pfx_pkg::word_t'(0) - req.dividend : req.dividend;
		b_mag = b_neg ? pfx_pkg::word_t'(0) - req.divisor : req.divisor;
	end

	// One restoring step: shift in the next dividend bit and trial subtract
	always_comb begin
		rem_shift = {rem_q, quo_q[pfx_pkg::WORD_W-1]};
		diff      = rem_shift - {1'b0, dvs_q};
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pfx_pkg::WORD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold the partial remainder and the quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= a_neg ^ b_neg;
			rem_q <= '0;
			quo_q <= a_mag;
			dvs_q <= b_mag;
		end else if (busy_q) begin
			if (!diff[pfx_pkg::WORD_W]) begin
				rem_q <= diff[pfx_pkg::WORD_W-1:0];
				quo_q <= {quo_q[pfx_pkg::WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[pfx_pkg::WORD_W-1:0];
				quo_q <= {quo_q[pfx_pkg::WORD_W-2:0], 1'b0};
			end
		end
	end

	// Apply the sign, truncating toward zero
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? pfx_pkg::word_t'(0) - quo_q : quo_q;

endmodule

// ----- src/postfix_expression_evaluator_top.sv -----
// Postfix (RPN) evaluator: takes one expression character per word on expr.
// Digits push 0..9; + - * / pop right then left operand and push the
// 32-bit wrapping result (division truncates toward zero); other characters
// are ignored. On a word with last set, the top value is popped and sent on
// result with a status (0 ok, 1 underflow, 2 divide by zero, 3 overflow; the
// first error seen wins), then the stack and the error are cleared. One word
// is handled at a time: a digit is pushed through the push state; + - *
// go through two registered stack reads, an execute state and a push,
// and / also goes through the one-bit-per-cycle restoring divider in the
// divide state; a zero divisor skips the divider. A word with last then
// passes through an emit state, which waits while the previous result is
// still waiting to be taken. The stack is a STACK_DEPTH x 32 memory
// with no clearing pass after reset.
module postfix_expression_evaluator_top #(
	parameter int unsigned STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	pfx_expr_if.sink     expr,
	pfx_result_if.source result
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	pfx_pkg::state_t    state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      cnt_dec;
	pfx_pkg::status_t   sticky_q;
	logic               err_set;
	pfx_pkg::status_t   err_code;
	logic               sticky_clr;

	logic [7:0]         sym_q;
	logic               last_q;
	logic               is_digit;
	logic               is_op;

	pfx_pkg::word_t     stack_mem [STACK_DEPTH];
	pfx_pkg::word_t     rd_data_q;
	logic               rd_en;
	logic               wr_en;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               rd_ok_q, rd_ok_d, rd_ok_ld;
	logic               pop_req;

	pfx_pkg::word_t     rhs_q;
	pfx_pkg::word_t     lhs_q;
	pfx_pkg::word_t     res_q, res_d;
	logic               rhs_ld;
	logic               lhs_ld;
	logic               res_ld;

	pfx_pkg::div_req_t  div_req;
	pfx_pkg::div_rsp_t  div_rsp;
	logic               div_start;

	logic               out_valid_q;
	pfx_pkg::word_t     out_value_q;
	logic [1:0]         out_status_q;
	logic               out_ld;

	// Classify the held character
	always_comb begin
		is_digit = 1'b0;
		is_op    = 1'b0;
		case (sym_q) inside
			[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]: is_digit = 1'b1;
			pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS,
			pfx_pkg::CH_STAR, pfx_pkg::CH_SLASH: is_op = 1'b1;
			default: ;
		endcase
	end

	assign cnt_dec = count_q - CW'(1);

	// Sequencer: next state and control
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		err_set    = 1'b0;
		err_code   = pfx_pkg::ST_OK;
		sticky_clr = 1'b0;
		pop_req    = 1'b0;
		rd_en      = 1'b0;
		rd_ok_ld   = 1'b0;
		rd_ok_d    = 1'b0;
		wr_en      = 1'b0;
		rd_addr    = cnt_dec[AW-1:0];
		wr_addr    = count_q[AW-1:0];
		rhs_ld     = 1'b0;
		lhs_ld     = 1'b0;
		res_ld     = 1'b0;
		res_d      = '0;
		div_start  = 1'b0;
		out_ld     = 1'b0;
		expr.ready = 1'b0;

		unique case (state_q)
			pfx_pkg::S_IDLE: begin
				expr.ready = 1'b1;
				if (expr.valid) begin
					state_d = pfx_pkg::S_DISPATCH;
				end
			end
			pfx_pkg::S_DISPATCH: begin
				if (is_digit) begin
					res_ld  = 1'b1;
					res_d   = pfx_pkg::word_t'(sym_q - pfx_pkg::CH_ZERO);
					state_d = pfx_pkg::S_PUSH;
				end else if (is_op) begin
					pop_req = 1'b1;
					state_d = pfx_pkg::S_RHS;
				end else begin
					state_d = pfx_pkg::S_FINISH;
				end
			end
			pfx_pkg::S_RHS: begin
				rhs_ld  = 1'b1;
				pop_req = 1'b1;
				state_d = pfx_pkg::S_LHS;
			end
			pfx_pkg::S_LHS: begin
				lhs_ld  = 1'b1;
				state_d = pfx_pkg::S_EXEC;
			end
			pfx_pkg::S_EXEC: begin
				case (sym_q)
					pfx_pkg::CH_PLUS: begin
						res_ld  = 1'b1;
						res_d   = lhs_q + rhs_q;
						state_d = pfx_pkg::S_PUSH;
					end
					pfx_pkg::CH_MINUS: begin
						res_ld  = 1'b1;
						res_d   = lhs_q - rhs_q;
						state_d = pfx_pkg::S_PUSH;
					end
					pfx_pkg::CH_STAR: begin
						res_ld  = 1'b1;
						res_d   = lhs_q * rhs_q;
						state_d = pfx_pkg::S_PUSH;
					end
					default: begin
						// Division: a zero divisor pushes zero
						if (rhs_q == '0) begin
							err_set  = 1'b1;
							err_code = pfx_pkg::ST_DIVZERO;
							res_ld   = 1'b1;
							state_d  = pfx_pkg::S_PUSH;
						end else begin
							div_start = 1'b1;
							state_d   = pfx_pkg::S_DIV;
						end
					end
				endcase
			end
			pfx_pkg::S_DIV: begin
				if (div_rsp.done) begin
					res_ld  = 1'b1;
					res_d   = div_rsp.quotient;
					state_d = pfx_pkg::S_PUSH;
				end
			end
			pfx_pkg::S_PUSH: begin
				if (count_q != CW'(STACK_DEPTH)) begin
					wr_en   = 1'b1;
					count_d = count_q + CW'(1);
				end else begin
					err_set  = 1'b1;
					err_code = pfx_pkg::ST_OVERFLOW;
				end
				state_d = pfx_pkg::S_FINISH;
			end
			pfx_pkg::S_FINISH: begin
				if (last_q) begin
					pop_req = 1'b1;
					state_d = pfx_pkg::S_EMIT;
				end else begin
					state_d = pfx_pkg::S_IDLE;
				end
			end
			pfx_pkg::S_EMIT: begin
				if (!out_valid_q || result.ready) begin
					out_ld     = 1'b1;
					count_d    = '0;
					sticky_clr = 1'b1;
					state_d    = pfx_pkg::S_IDLE;
				end
			end
			default: state_d = pfx_pkg::S_IDLE;
		endcase

		// Pop: read the top entry, or flag underflow and read as zero
		if (pop_req) begin
			rd_ok_ld = 1'b1;
			if (count_q == '0) begin
				err_set  = 1'b1;
				err_code = pfx_pkg::ST_UNDERFLOW;
			end else begin
				count_d = cnt_dec;
				rd_en   = 1'b1;
				rd_ok_d = 1'b1;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfx_pkg::S_IDLE;
			count_q     <= '0;
			sticky_q    <= pfx_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (sticky_clr) begin
				sticky_q <= pfx_pkg::ST_OK;
			end else if (err_set && sticky_q == pfx_pkg::ST_OK) begin
				sticky_q <= err_code;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operand stack memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (expr.valid && expr.ready) begin
			sym_q  <= expr.symbol;
			last_q <= expr.last;
		end
		if (rd_ok_ld) begin
			rd_ok_q <= rd_ok_d;
		end
		if (rhs_ld) begin
			rhs_q <= rd_ok_q ? rd_data_q : '0;
		end
		if (lhs_ld) begin
			lhs_q <= rd_ok_q ? rd_data_q : '0;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_ld) begin
			out_value_q  <= rd_ok_q ? rd_data_q : '0;
			out_status_q <= sticky_q;
		end
	end

	// Divider
	always_comb begin
		div_req.start    = div_start;
		div_req.dividend = lhs_q;
		div_req.divisor  = rhs_q;
	end

	pfx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign result.valid  = out_valid_q;
	assign result.value  = out_value_q;
	assign result.status = out_status_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> count_q != CW'(STACK_DEPTH))
		else $error("push into a full stack");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == pfx_pkg::S_DIV)
		else $error("divider finished outside the divide state");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		expr.valid && expr.ready |=> state_q == pfx_pkg::S_DISPATCH)
		else $error("accepted word not dispatched");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |=> result.valid && count_q == '0 && sticky_q == pfx_pkg::ST_OK)
		else $error("result not shown or state not cleared");
`endif

endmodule
